[rtl/bwmv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwmv_pkg
// Shared constants, command codes and binary32 arithmetic helpers for the
// bf16 weight matrix-vector engine.
// ----------------------------------------------------------------------------
package bwmv_pkg;

  localparam int MAX_COLS  = 4096;
  localparam int COL_BITS  = $clog2(MAX_COLS);
  localparam int ROW_BITS  = 16;
  localparam int CFG_BITS  = 13;
  localparam int VEC_BITS  = 32;
  localparam int WGT_BITS  = 16;

  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

  typedef enum logic [0:0] {
    CMD_LOAD   = 1'b0,
    CMD_WEIGHT = 1'b1
  } cmd_t;

  // Normalize, round to nearest even and encode. e is the biased exponent
  // that bit 31 of sig would carry.
  function automatic logic [31:0] fp_pack(input logic sign, input logic signed [11:0] e,
                                          input logic [31:0] sig);
    logic [5:0]         lz;
    logic [31:0]        norm;
    logic signed [11:0] en;
    logic signed [11:0] dn;
    logic [5:0]         sh;
    logic [63:0]        wide;
    logic [31:0]        kept;
    logic [23:0]        mant;
    logic               g;
    logic               st;
    logic               up;
    logic [24:0]        m25;
    logic [8:0]         field;
    logic [31:0]        res;
    lz = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (sig[i]) lz = 6'(31 - i);
    end
    norm = sig << lz;
    en   = e - $signed({6'b0, lz});
    if (en < 12'sd1) begin
      dn    = 12'sd1 - en;
      sh    = (dn > 12'sd32) ? 6'd32 : dn[5:0];
      field = 9'd0;
    end else begin
      dn    = 12'sd0;
      sh    = 6'd0;
      field = en[8:0];
    end
    wide = {norm, 32'b0} >> sh;
    kept = wide[63:32];
    mant = kept[31:8];
    g    = kept[7];
    st   = (|kept[6:0]) | (|wide[31:0]);
    up   = g & (st | mant[0]);
    m25  = {1'b0, mant} + {24'b0, up};
    if (sig == 32'b0) begin
      res = {sign, 31'b0};
    end else if (field == 9'd0) begin
      res = {sign, 7'b0, m25[23], m25[22:0]};
    end else begin
      if (m25[24]) field = field + 9'd1;
      if (field >= 9'd255) begin
        res = {sign, 8'hFF, 23'b0};
      end else begin
        res = {sign, field[7:0], m25[24] ? 23'b0 : m25[22:0]};
      end
    end
    return res;
  endfunction

  // binary32 times widened bf16, one rounding.
  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [15:0] w);
    logic               s;
    logic               a_nan;
    logic               b_nan;
    logic               a_inf;
    logic               b_inf;
    logic               a_zero;
    logic               b_zero;
    logic [23:0]        ma;
    logic [7:0]         mb;
    logic [31:0]        p;
    logic signed [11:0] e;
    logic [31:0]        res;
    s      = a[31] ^ w[15];
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
    b_nan  = (w[14:7] == 8'hFF) && (w[6:0] != 7'b0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
    b_inf  = (w[14:7] == 8'hFF) && (w[6:0] == 7'b0);
    a_zero = (a[30:0] == 31'b0);
    b_zero = (w[14:0] == 15'b0);
    ma     = {a[30:23] != 8'h00, a[22:0]};
    mb     = {w[14:7] != 8'h00, w[6:0]};
    p      = {8'b0, ma} * {24'b0, mb};
    e      = $signed({4'b0, (a[30:23] == 8'h00) ? 8'd1 : a[30:23]})
           + $signed({4'b0, (w[14:7] == 8'h00) ? 8'd1 : w[14:7]}) - 12'sd126;
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      res = FP_QNAN;
    end else if (a_inf || b_inf) begin
      res = {s, 8'hFF, 23'b0};
    end else begin
      res = fp_pack(s, e, p);
    end
    return res;
  endfunction

  // binary32 add, one rounding.
  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [7:0]  diff;
    logic [5:0]  sh;
    logic [31:0] xs;
    logic [63:0] wide;
    logic [31:0] ys;
    logic [31:0] sum;
    logic        same;
    logic [31:0] res;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    ex   = (x[30:23] == 8'h00) ? 8'd1 : x[30:23];
    ey   = (y[30:23] == 8'h00) ? 8'd1 : y[30:23];
    diff = ex - ey;
    sh   = (diff > 8'd32) ? 6'd32 : diff[5:0];
    xs   = {1'b0, x[30:23] != 8'h00, x[22:0], 7'b0};
    wide = {1'b0, y[30:23] != 8'h00, y[22:0], 7'b0, 32'b0} >> sh;
    ys   = wide[63:32] | {31'b0, |wide[31:0]};
    same = (x[31] == y[31]);
    sum  = same ? (xs + ys) : (xs - ys);
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      res = FP_QNAN;
    end else if (a_inf) begin
      res = a;
    end else if (b_inf) begin
      res = b;
    end else if (!same && (sum == 32'b0)) begin
      res = 32'b0;
    end else begin
      res = fp_pack(x[31], $signed({4'b0, ex}) + 12'sd1, sum);
    end
    return res;
  endfunction

endpackage

[rtl/bwmv_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwmv_in_if / bwmv_out_if
// Valid/ready channels for command items and row results.
// ----------------------------------------------------------------------------
interface bwmv_in_if;
  import bwmv_pkg::*;
  logic                valid;
  logic                ready;
  cmd_t                cmd;
  logic [COL_BITS-1:0] vec_index;
  logic [VEC_BITS-1:0] vec_value;
  logic [WGT_BITS-1:0] weight;
  modport source (output valid, cmd, vec_index, vec_value, weight, input ready);
  modport sink   (input valid, cmd, vec_index, vec_value, weight, output ready);
endinterface

interface bwmv_out_if;
  import bwmv_pkg::*;
  logic                valid;
  logic                ready;
  logic [ROW_BITS-1:0] row_index;
  logic [31:0]         dot_value;
  modport source (output valid, row_index, dot_value, input ready);
  modport sink   (input valid, row_index, dot_value, output ready);
endinterface

[rtl/bf16_weight_matvec_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf16_weight_matvec_engine
// Streams bf16 weights against a stored fp32 vector and emits one fp32 dot
// product per matrix row.
// ----------------------------------------------------------------------------
// Pipeline: a row's last weight passes the vector read stage, multiply stage
// and accumulate into the output register. Throughput: one transaction per
// cycle unless a result stalls on a full output register; the accumulator add
// is combinational and the vector store gives one registered read per cycle.
// Reset: rst clears pipeline valids, positions, accumulator and the output
// valid; col_count returns to 1. The vector store is not cleared.
// ----------------------------------------------------------------------------
module bf16_weight_matvec_engine (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [bwmv_pkg::CFG_BITS-1:0] cfg_wdata,
  bwmv_in_if.sink                  item,
  bwmv_out_if.source               result
);
  import bwmv_pkg::*;

  logic [CFG_BITS-1:0] col_count;
  logic [CFG_BITS-1:0] eff_cols;
  logic [COL_BITS-1:0] col;
  logic [ROW_BITS-1:0] row;
  logic                is_last;
  logic                advance;
  logic                accept;

  // vector store
  logic [31:0] vstore [MAX_COLS];

  // stage 1: vector element read
  logic                s1_valid;
  cmd_t                s1_cmd;
  logic [15:0]         s1_w;
  logic                s1_last;
  logic [ROW_BITS-1:0] s1_row;
  logic [31:0]         s1_x;

  // stage 2: rounded product
  logic                s2_valid;
  cmd_t                s2_cmd;
  logic [31:0]         s2_prod;
  logic                s2_last;
  logic [ROW_BITS-1:0] s2_row;

  logic [31:0] acc;
  logic [31:0] sum;
  logic        emit;

  // Clamp the column count to the legal range.
  always_comb begin
    if (col_count == '0) begin
      eff_cols = CFG_BITS'(1);
    end else if (col_count > CFG_BITS'(MAX_COLS)) begin
      eff_cols = CFG_BITS'(MAX_COLS);
    end else begin
      eff_cols = col_count;
    end
  end

  assign is_last = (CFG_BITS'(col) + CFG_BITS'(1)) >= eff_cols;

  // Stall only when a row result would land on a full output register.
  assign emit    = s2_valid && (s2_cmd == CMD_WEIGHT) && s2_last;
  assign advance = !(result.valid && !result.ready && emit);
  assign item.ready = advance;
  assign accept  = item.valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= CFG_BITS'(1);
    end else if (cfg_we) begin
      col_count <= cfg_wdata;
    end
  end

  // Track column and row at the input so the store address is ready at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (item.cmd == CMD_LOAD) begin
        col <= '0;
        row <= '0;
      end else if (is_last) begin
        col <= '0;
        row <= row + ROW_BITS'(1);
      end else begin
        col <= col + COL_BITS'(1);
      end
    end
  end

  // Write on a load transaction; read the current column for weights.
  always_ff @(posedge clk) begin
    if (accept && (item.cmd == CMD_LOAD)) begin
      vstore[item.vec_index] <= item.vec_value;
    end
    if (advance) begin
      s1_x <= vstore[col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= item.valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cmd  <= item.cmd;
      s1_w    <= item.weight;
      s1_last <= is_last;
      s1_row  <= row;
      s2_cmd  <= s1_cmd;
      s2_prod <= fp_mul(s1_x, s1_w);
      s2_last <= s1_last;
      s2_row  <= s1_row;
    end
  end

  assign sum = fp_add(acc, s2_prod);

  // Accumulate; a load or a finished row drops the sum back to +0.0.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (advance && s2_valid) begin
      if ((s2_cmd == CMD_LOAD) || s2_last) begin
        acc <= '0;
      end else begin
        acc <= sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance && emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result.row_index <= s2_row;
      if ((sum[30:23] == 8'hFF) && (sum[22:0] != 23'b0)) begin
        result.dot_value <= FP_QNAN;
      end else begin
        result.dot_value <= sum;
      end
    end
  end

endmodule

[rtl/bwmv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwmv_checker
// Port-level checks of the result and input channels, bound to the engine.
// ----------------------------------------------------------------------------
module bwmv_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_row,
  input logic [31:0] out_dot
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_row) && $stable(out_dot))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // input backs up only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while result side free");

endmodule

bind bf16_weight_matvec_engine bwmv_checker u_bwmv_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (item.valid),
  .in_ready (item.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .out_row  (result.row_index),
  .out_dot  (result.dot_value)
);
